// ===== rtl/mmras_pkg.sv =====
package mmras_pkg;

  // Data path width and fixed step of the program counter
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegFldW  = 5;
  localparam logic [DataW-1:0] PcStep = DataW'(4);

  // Instruction codes
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MULT  = 4'd2,
    OP_DIV   = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_BEQ   = 4'd6,
    OP_BNE   = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd9,
    OP_JUMP  = 4'd10
  } opcode_e;

  // Register file read port selection
  typedef enum logic [1:0] {
    RSEL_A,
    RSEL_B,
    RSEL_C
  } rsel_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_OPER,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [RegFldW-1:0] first_reg;
    logic [RegFldW-1:0] second_reg;
    logic [RegFldW-1:0] third_reg;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        pc_value;
    logic               branch_taken;
    logic signed [31:0] result_value;
    logic               div_zero;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_item;
    rsel_e rd_sel;
    logic  cap_a;
    logic  cap_b;
    logic  cap_c;
    logic  exec;
    logic  div_start;
    logic  div_load;
    logic  commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_run;
    logic div_done;
  } sts_t;

  // Reduce a register field modulo the register count by restoring subtraction
  function automatic logic [5:0] reg_mod(logic [RegFldW-1:0] field, int unsigned m);
    int unsigned v;
    v = field;
    for (int k = 4; k >= 0; k--) begin
      if (v >= (m << k)) begin
        v = v - (m << k);
      end
    end
    return v[5:0];
  endfunction

endpackage

// ===== rtl/mini_mips_register_alu_step.sv =====
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_ready_o   | in_item_i  (opcode, regs, immediate)
// out      | output    | out_valid_o / out_ready_i | out_item_o (pc, taken, result, div_zero)
//
// An item passes from acceptance to the next through accept, three reads on the single
// read port of the register file, last operand capture, execute and commit.
// A divide with a nonzero divisor adds a pass through the divider, one quotient bit per cycle.
// Reset clears the program counter and marks every register as zero at once.
// A result waits in the output register while a new item is accepted; commit stalls
// only when the previous result has not been taken.
module mini_mips_register_alu_step
  import mmras_pkg::*;
#(
  parameter int unsigned NumRegs = RegCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  mmras_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mmras_dp #(
    .NumRegs (NumRegs)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/mmras_ram.sv =====
module mmras_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mmras_div.sv =====
module mmras_div
  import mmras_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DataW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [DataW:0]    rem_q, rem_d;
  logic [DataW-1:0]  quo_q, quo_d;
  logic [DataW-1:0]  den_q, den_d;
  logic [DataW:0]    rem_sh;
  logic [DataW:0]    trial;

  // One quotient bit per cycle on the magnitudes
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DataW-1:0], quo_q[DataW-1]};
    trial  = rem_sh - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW - 1);
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      rem_d  = '0;
      quo_d  = num_i[DataW-1] ? (DataW'(0) - num_i) : num_i;
      den_d  = den_i[DataW-1] ? (DataW'(0) - den_i) : den_i;
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial;
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  // Restore the sign; the most negative quotient wraps onto itself
  assign done_o = done_q;
  assign quo_o  = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/mmras_dp.sv =====
module mmras_dp
  import mmras_pkg::*;
#(
  parameter int unsigned NumRegs = RegCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  in_item_t         item_q;
  logic [IdxW-1:0]  ra_idx, rb_idx, rc_idx, rd_addr;
  logic [NumRegs-1:0] valid_q;
  logic             vld_rd_q;
  logic [DataW-1:0] ram_rdata, rd_data;
  logic [DataW-1:0] a_q, b_q, c_q;
  logic [DataW-1:0] mul_lo;
  logic [DataW-1:0] res_d, result_q;
  logic             taken_d, taken_q;
  logic             dz_d, dz_q;
  logic             wr_d, write_q;
  logic [DataW-1:0] pc_q, pc_nx_d, pc_nx_q;
  logic             div_done;
  logic [DataW-1:0] div_quo;
  out_item_t        out_q;

  // Register indexes reduced to the file depth
  assign ra_idx = IdxW'(reg_mod(item_q.first_reg, NumRegs));
  assign rb_idx = IdxW'(reg_mod(item_q.second_reg, NumRegs));
  assign rc_idx = IdxW'(reg_mod(item_q.third_reg, NumRegs));

  always_comb begin
    unique case (cmd_i.rd_sel)
      RSEL_A:  rd_addr = ra_idx;
      RSEL_B:  rd_addr = rb_idx;
      RSEL_C:  rd_addr = rc_idx;
      default: rd_addr = ra_idx;
    endcase
  end

  mmras_ram #(
    .Width (DataW),
    .Depth (NumRegs)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & write_q),
    .waddr_i (ra_idx),
    .wdata_i (result_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Entries never written since reset read as zero
  assign rd_data = vld_rd_q ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      pc_q     <= '0;
    end else begin
      vld_rd_q <= valid_q[rd_addr];
      if (cmd_i.commit) begin
        pc_q <= pc_nx_q;
        if (write_q) begin
          valid_q[ra_idx] <= 1'b1;
        end
      end
    end
  end

  assign mul_lo = b_q * c_q;

  // Evaluate the instruction on the captured operands
  always_comb begin
    res_d   = '0;
    taken_d = 1'b0;
    dz_d    = 1'b0;
    wr_d    = 1'b0;
    unique case (item_q.opcode)
      OP_ADD:   begin res_d = b_q + c_q; wr_d = 1'b1; end
      OP_SUB:   begin res_d = b_q - c_q; wr_d = 1'b1; end
      OP_MULT:  begin res_d = mul_lo;    wr_d = 1'b1; end
      OP_DIV:   begin dz_d = (c_q == '0); wr_d = 1'b1; end
      OP_AND:   begin res_d = b_q & c_q; wr_d = 1'b1; end
      OP_OR:    begin res_d = b_q | c_q; wr_d = 1'b1; end
      OP_BEQ:   taken_d = (a_q == b_q);
      OP_BNE:   taken_d = (a_q != b_q);
      OP_LOAD:  begin res_d = item_q.immediate; wr_d = 1'b1; end
      OP_STORE: res_d = a_q;
      OP_JUMP:  taken_d = 1'b1;
      default:  ;
    endcase
    pc_nx_d = pc_q + PcStep + (taken_d ? DataW'(item_q.immediate) : '0);
  end

  // Capture the item, operands and results as the controller steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.cap_a) begin
      a_q <= rd_data;
    end
    if (cmd_i.cap_b) begin
      b_q <= rd_data;
    end
    if (cmd_i.cap_c) begin
      c_q <= rd_data;
    end
    if (cmd_i.exec) begin
      result_q <= res_d;
      taken_q  <= taken_d;
      dz_q     <= dz_d;
      write_q  <= wr_d;
      pc_nx_q  <= pc_nx_d;
    end else if (cmd_i.div_load) begin
      result_q <= div_quo;
    end
    if (cmd_i.commit) begin
      out_q.pc_value     <= pc_nx_q;
      out_q.branch_taken <= taken_q;
      out_q.result_value <= $signed(result_q);
      out_q.div_zero     <= dz_q;
    end
  end

  mmras_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (b_q),
    .den_i   (c_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign sts_o.div_run  = (item_q.opcode == OP_DIV) && (c_q != '0);
  assign sts_o.div_done = div_done;
  assign out_item_o     = out_q;

endmodule

// ===== rtl/mmras_ctrl.sv =====
module mmras_ctrl
  import mmras_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence reads, execute, optional divide, then commit into the output register
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.rd_sel = RSEL_A;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd_o.rd_sel = RSEL_A;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_sel = RSEL_B;
        cmd_o.cap_a  = 1'b1;
        state_d = ST_RD_C;
      end
      ST_RD_C: begin
        cmd_o.rd_sel = RSEL_C;
        cmd_o.cap_b  = 1'b1;
        state_d = ST_OPER;
      end
      ST_OPER: begin
        cmd_o.cap_c = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.div_run) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_load = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mmras_checker.sv =====
module mmras_checker
  import mmras_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // No result shows once reset has been seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Only one item is in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

  // A new result appears only while an item is in work
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in work");

  // A zero divisor gives a zero result and no branch
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.div_zero |->
      out_item_o.result_value == '0 && !out_item_o.branch_taken)
    else $error("divide by zero result malformed");

endmodule

bind mini_mips_register_alu_step mmras_checker u_checker (.*);

// ===== bench/mini_mips_register_alu_step_tb.sv =====
module mini_mips_register_alu_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmras_pkg::*;

  // Opcodes the block leaves unused
  localparam logic [3:0] OpUnusedLo = 4'd11;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  localparam int unsigned ItemsPerPhase = 480;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned TailCycles    = 60;
  localparam int unsigned CycleLimit    = 1_000_000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Architectural state tracked alongside the block
  logic [31:0] arch_regs [RegCount];
  logic [31:0] arch_pc;

  out_item_t   pending_results [$];
  out_item_t   oldest_result;
  dir_row_t    dir_rows [$];

  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct    = 0;
  bit          rx_hold_req     = 1'b0;
  int unsigned rx_hold_left    = 0;
  int unsigned mismatch_cnt    = 0;
  int unsigned cycle_cnt       = 0;

  mini_mips_register_alu_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #2 clk_i = ~clk_i;

  // Execute one instruction on the tracked state and return its result
  function automatic out_item_t execute_instr(in_item_t it);
    out_item_t   r;
    int unsigned ia;
    int unsigned ib;
    int unsigned ic;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] res;
    logic [31:0] mag_b;
    logic [31:0] mag_c;
    logic [31:0] quot;
    logic        tk;
    logic        dz;
    logic        wr;
    ia = it.first_reg % RegCount;
    ib = it.second_reg % RegCount;
    ic = it.third_reg % RegCount;
    a = arch_regs[ia];
    b = arch_regs[ib];
    c = arch_regs[ic];
    res = '0;
    tk = 1'b0;
    dz = 1'b0;
    wr = 1'b0;
    arch_pc = arch_pc + PcStep;
    case (it.opcode)
      OP_ADD: begin
        res = b + c;
        wr = 1'b1;
      end
      OP_SUB: begin
        res = b - c;
        wr = 1'b1;
      end
      OP_MULT: begin
        res = b * c;
        wr = 1'b1;
      end
      OP_DIV: begin
        wr = 1'b1;
        if (c == '0) begin
          dz = 1'b1;
        end else begin
          // Divide magnitudes, then fix the sign; truncates toward zero
          mag_b = b[31] ? -b : b;
          mag_c = c[31] ? -c : c;
          quot = mag_b / mag_c;
          res = (b[31] ^ c[31]) ? -quot : quot;
        end
      end
      OP_AND: begin
        res = b & c;
        wr = 1'b1;
      end
      OP_OR: begin
        res = b | c;
        wr = 1'b1;
      end
      OP_BEQ: tk = (a == b);
      OP_BNE: tk = (a != b);
      OP_LOAD: begin
        res = it.immediate;
        wr = 1'b1;
      end
      OP_STORE: res = a;
      OP_JUMP: tk = 1'b1;
      default: ;
    endcase
    if (tk) begin
      arch_pc = arch_pc + it.immediate;
    end
    if (wr) begin
      arch_regs[ia] = res;
    end
    r.pc_value     = arch_pc;
    r.branch_taken = tk;
    r.result_value = res;
    r.div_zero     = dz;
    return r;
  endfunction

  // Append one directed row; the expected item is used only when typed is set
  task automatic add_row(input logic [3:0] op, input int unsigned ra, input int unsigned rb,
                         input int unsigned rc, input logic [31:0] imm, input bit typed,
                         input logic [31:0] pc, input bit tk, input logic [31:0] res,
                         input bit dz);
    dir_row_t row;
    row.item.opcode        = op;
    row.item.first_reg     = RegFldW'(ra);
    row.item.second_reg    = RegFldW'(rb);
    row.item.third_reg     = RegFldW'(rc);
    row.item.immediate     = imm;
    row.typed              = typed;
    row.want.pc_value      = pc;
    row.want.branch_taken  = tk;
    row.want.result_value  = res;
    row.want.div_zero      = dz;
    dir_rows.push_back(row);
  endtask

  // Draw one instruction, mostly loads and arithmetic so registers fill with varied values
  function automatic in_item_t rand_instr();
    in_item_t    it;
    int unsigned sel;
    it.opcode     = OP_STORE;
    it.first_reg  = RegFldW'($urandom);
    it.second_reg = RegFldW'($urandom);
    it.third_reg  = RegFldW'($urandom);
    it.immediate  = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      it.opcode = OP_LOAD;
      case ($urandom_range(0, 5))
        0: it.immediate = $urandom;
        1: it.immediate = $urandom_range(0, 32) - 16;
        2: it.immediate = 32'h8000_0000;
        3: it.immediate = 32'h7fff_ffff;
        4: it.immediate = 32'hffff_ffff;
        default: it.immediate = '0;
      endcase
    end else if (sel < 70) begin
      it.opcode = 4'($urandom_range(OP_ADD, OP_OR));
    end else if (sel < 85) begin
      it.opcode = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
      if ($urandom_range(0, 1)) begin
        it.second_reg = it.first_reg;
      end
      if ($urandom_range(0, 1)) begin
        it.immediate = ($urandom_range(0, 64) - 32) * 4;
      end
    end else if (sel < 92) begin
      it.opcode = OP_STORE;
    end else if (sel < 97) begin
      it.opcode = OP_JUMP;
    end else begin
      it.opcode = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_out);
    out_item_t guess;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    guess = execute_instr(it);
    pending_results.push_back(typed ? typed_out : guess);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = LongHold;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: %p", out_item);
        mismatch_cnt++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.pc_value !== oldest_result.pc_value) begin
          $error("pc_value: expected %h, got %h", oldest_result.pc_value, out_item.pc_value);
          mismatch_cnt++;
        end
        if (out_item.branch_taken !== oldest_result.branch_taken) begin
          $error("branch_taken: expected %b, got %b",
                 oldest_result.branch_taken, out_item.branch_taken);
          mismatch_cnt++;
        end
        if (out_item.result_value !== oldest_result.result_value) begin
          $error("result_value: expected %h, got %h",
                 oldest_result.result_value, out_item.result_value);
          mismatch_cnt++;
        end
        if (out_item.div_zero !== oldest_result.div_zero) begin
          $error("div_zero: expected %b, got %b", oldest_result.div_zero, out_item.div_zero);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("mini_mips_register_alu_step: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (arch_regs[i]) begin
      arch_regs[i] = '0;
    end
    arch_pc = '0;

    // Directed rows: typed expectations only where they are obvious
    //      op          ra  rb  rc  immediate     typed pc     tk  result        dz
    add_row(OP_STORE,   0,  0,  0,  32'h0000_0000, 1, 32'd4,  0, 32'h0000_0000, 0);
    add_row(OP_LOAD,    1,  0,  0,  32'h7fff_ffff, 1, 32'd8,  0, 32'h7fff_ffff, 0);
    add_row(OP_LOAD,    2,  0,  0,  32'h8000_0000, 1, 32'd12, 0, 32'h8000_0000, 0);
    add_row(OP_LOAD,    3,  0,  0,  32'hffff_ffff, 1, 32'd16, 0, 32'hffff_ffff, 0);
    add_row(OP_ADD,     4,  1,  1,  32'h0000_0000, 1, 32'd20, 0, 32'hffff_fffe, 0);
    add_row(OP_SUB,     5,  2,  1,  32'h1234_5678, 0, '0,     0, '0,            0);
    add_row(OP_MULT,    6,  1,  3,  32'h0000_0000, 0, '0,     0, '0,            0);
    // Most negative value over minus one wraps
    add_row(OP_DIV,     7,  2,  3,  32'h0000_0000, 1, 32'd32, 0, 32'h8000_0000, 0);
    // Zero divisor
    add_row(OP_DIV,     8,  1,  0,  32'h0000_0000, 1, 32'd36, 0, 32'h0000_0000, 1);
    add_row(OP_LOAD,   10,  0,  0,  32'hffff_fff9, 0, '0,     0, '0,            0);
    add_row(OP_LOAD,   11,  0,  0,  32'h0000_0002, 0, '0,     0, '0,            0);
    add_row(OP_DIV,    12, 10, 11,  32'h0000_0000, 0, '0,     0, '0,            0);
    add_row(OP_DIV,    13, 11, 10,  32'h0000_0000, 0, '0,     0, '0,            0);
    add_row(OP_AND,    14,  1,  3,  32'h0000_0000, 0, '0,     0, '0,            0);
    add_row(OP_OR,     15,  2, 11,  32'h0000_0000, 0, '0,     0, '0,            0);
    add_row(OP_BEQ,     0,  0,  0,  32'h0000_0100, 0, '0,     0, '0,            0);
    add_row(OP_BNE,     0,  0,  0,  32'h0000_0100, 0, '0,     0, '0,            0);
    add_row(OP_BEQ,     1,  2,  0,  32'h0000_0040, 0, '0,     0, '0,            0);
    add_row(OP_BNE,     1,  2,  0,  32'hffff_fff8, 0, '0,     0, '0,            0);
    add_row(OP_JUMP,    0,  0,  0,  32'h7fff_ffff, 0, '0,     0, '0,            0);
    add_row(OP_JUMP,   31, 31, 31,  32'h8000_0000, 0, '0,     0, '0,            0);
    add_row(OpUnusedLo, 9,  9,  9,  32'hffff_ffff, 0, '0,     0, '0,            0);
    add_row(OpUnusedHi,31, 31, 31,  32'h5555_aaaa, 0, '0,     0, '0,            0);
    add_row(OP_LOAD,   31,  0,  0,  32'ha5a5_a5a5, 0, '0,     0, '0,            0);
    // Register zero takes writes like any other
    add_row(OP_ADD,     0, 31, 31,  32'h0000_0000, 0, '0,     0, '0,            0);
    // Destination is also a source
    add_row(OP_ADD,    31, 31, 31,  32'h0000_0000, 0, '0,     0, '0,            0);
    add_row(OP_STORE,   0,  0,  0,  32'h0000_0000, 0, '0,     0, '0,            0);

    // Hold reset, then release it on a clock edge
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with no idling
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          rx_stall_pct    = 0;
        end
        1: begin
          sender_idle_pct = 79;
          rx_stall_pct    = 0;
          // Hold the receiver off while items keep coming
          rx_hold_req = 1'b1;
        end
        2: begin
          sender_idle_pct = 0;
          rx_stall_pct    = 79;
        end
        default: begin
          sender_idle_pct = 13;
          rx_stall_pct    = 13;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_item(rand_instr(), 1'b0, '0);
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("mini_mips_register_alu_step: match");
    end else begin
      $display("mini_mips_register_alu_step: mismatch");
    end
    $finish;
  end

endmodule
